@@ rtl/tun_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and stage records for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int OUT_WIDTH       = 16;
  localparam int FRAC_BITS       = 14;
  localparam int MAG_WIDTH       = 31;
  localparam int SQ_WIDTH        = 2 * MAG_WIDTH;
  localparam int SUM_WIDTH       = 64;
  localparam int LEN_WIDTH       = 32;
  localparam int SQRT_STEPS      = 32;
  localparam int QUO_BITS        = FRAC_BITS + 1;
  localparam int REM_WIDTH       = MAG_WIDTH + FRAC_BITS + 2;
  localparam int LATENCY         = 61;
  localparam logic signed [OUT_WIDTH-1:0] UNIT_POS = OUT_WIDTH'(16384);
  localparam logic signed [OUT_WIDTH-1:0] UNIT_NEG = -OUT_WIDTH'(16384);

  // record handed along the square root cells
  typedef struct packed {
    logic                             valid;
    logic                             degen;
    logic [2:0]                       neg;
    logic [2:0][MAG_WIDTH-1:0]        m;
    logic [SUM_WIDTH-1:0]             n;
    logic [SUM_WIDTH-1:0]             res;
  } sq_t;

  // record handed along the divider cells
  typedef struct packed {
    logic                             valid;
    logic                             degen;
    logic [2:0]                       neg;
    logic [LEN_WIDTH-1:0]             len;
    logic [2:0][REM_WIDTH-1:0]        rem;
    logic [2:0][QUO_BITS-1:0]         q;
  } div_t;

endpackage

@@ rtl/tun_shift_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_shift_cell
// One prescale step: shifts all three magnitudes right by SHIFT when the
// largest one, shifted right by TEST_SHIFT, stays at or above 2^31.
// ----------------------------------------------------------------------------
module tun_shift_cell #(
  parameter int MW         = 33,
  parameter int TEST_SHIFT = 1,
  parameter int SHIFT      = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_degen,
  input  logic [2:0]          in_neg,
  input  logic [2:0][MW-1:0]  in_mag,
  input  logic [MW-1:0]       in_big,
  output logic                out_valid,
  output logic                out_degen,
  output logic [2:0]          out_neg,
  output logic [2:0][MW-1:0]  out_mag,
  output logic [MW-1:0]       out_big
);
  import tun_pkg::*;

  localparam logic [MW-1:0] LIMIT = MW'(1) << MAG_WIDTH;

  logic take;

  // shift decision from the largest magnitude
  assign take = (in_big >> TEST_SHIFT) >= LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_degen <= in_degen;
    out_neg   <= in_neg;
    for (int i = 0; i < 3; i++) begin
      out_mag[i] <= take ? (in_mag[i] >> SHIFT) : in_mag[i];
    end
    out_big <= take ? (in_big >> SHIFT) : in_big;
  end

endmodule

@@ rtl/tun_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_sqrt_cell
// One digit of the integer square root: settles one result bit per cell.
// ----------------------------------------------------------------------------
module tun_sqrt_cell #(
  parameter int BIT_IDX = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  tun_pkg::sq_t in_rec,
  output tun_pkg::sq_t out_rec
);
  import tun_pkg::*;

  localparam logic [SUM_WIDTH-1:0] ONE_BIT = SUM_WIDTH'(1) << (2 * BIT_IDX);

  logic [SUM_WIDTH-1:0] trial;
  logic                 fits;
  sq_t                  rec_next;

  // trial subtract of res + bit
  always_comb begin
    trial    = in_rec.res + ONE_BIT;
    fits     = in_rec.n >= trial;
    rec_next = in_rec;
    if (fits) begin
      rec_next.n   = in_rec.n - trial;
      rec_next.res = (in_rec.res >> 1) + ONE_BIT;
    end else begin
      rec_next.res = in_rec.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_rec.valid <= 1'b0;
    end else begin
      out_rec.valid <= in_rec.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rec.degen <= rec_next.degen;
    out_rec.neg   <= rec_next.neg;
    out_rec.m     <= rec_next.m;
    out_rec.n     <= rec_next.n;
    out_rec.res   <= rec_next.res;
  end

endmodule

@@ rtl/tun_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_div_cell
// One quotient bit of the restoring divide, for all three lanes at once.
// ----------------------------------------------------------------------------
module tun_div_cell #(
  parameter int BIT_IDX = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  tun_pkg::div_t in_rec,
  output tun_pkg::div_t out_rec
);
  import tun_pkg::*;

  logic [REM_WIDTH-1:0] dsr;
  div_t                 rec_next;

  // compare and subtract the divisor shifted to this bit
  always_comb begin
    dsr      = REM_WIDTH'(in_rec.len) << BIT_IDX;
    rec_next = in_rec;
    for (int i = 0; i < 3; i++) begin
      if (in_rec.rem[i] >= dsr) begin
        rec_next.rem[i]        = in_rec.rem[i] - dsr;
        rec_next.q[i][BIT_IDX] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_rec.valid <= 1'b0;
    end else begin
      out_rec.valid <= in_rec.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rec.degen <= rec_next.degen;
    out_rec.neg   <= rec_next.neg;
    out_rec.len   <= rec_next.len;
    out_rec.rem   <= rec_next.rem;
    out_rec.q     <= rec_next.q;
  end

endmodule

@@ rtl/triangle_unit_normal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle, signed Q1.14, fully pipelined.
// ----------------------------------------------------------------------------
// A triangle is taken in every cycle that start is high; busy stays low.
// Each result appears on done exactly 61 cycles after its transfer and is
// held for one cycle only, so the receiver must capture it then. The delay
// is set by the chain: edges, products, cross terms, largest magnitude,
// seven prescale cells, squares, sum, 32 square root cells (one root bit
// each), 15 divider cells (one quotient bit each) and the output register.
// A zero cross product gives a zero normal with degenerate set.
// ----------------------------------------------------------------------------
module triangle_unit_normal #(
  parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_WIDTH-1:0]         first_x,
  input  logic signed [COORD_WIDTH-1:0]         first_y,
  input  logic signed [COORD_WIDTH-1:0]         first_z,
  input  logic signed [COORD_WIDTH-1:0]         second_x,
  input  logic signed [COORD_WIDTH-1:0]         second_y,
  input  logic signed [COORD_WIDTH-1:0]         second_z,
  input  logic signed [COORD_WIDTH-1:0]         third_x,
  input  logic signed [COORD_WIDTH-1:0]         third_y,
  input  logic signed [COORD_WIDTH-1:0]         third_z,
  output logic                                  done,
  output logic signed [tun_pkg::OUT_WIDTH-1:0]  normal_x,
  output logic signed [tun_pkg::OUT_WIDTH-1:0]  normal_y,
  output logic signed [tun_pkg::OUT_WIDTH-1:0]  normal_z,
  output logic                                  degenerate
);
  import tun_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int EW = CW + 1;
  localparam int PW = 2 * CW;
  localparam int NW = PW + 1;
  localparam int MW = (NW > MAG_WIDTH + 1) ? NW : MAG_WIDTH + 1;
  localparam int NSH = 7;

  assign busy = 1'b0;

  // ---------------- edges as sign and magnitude ----------------
  logic [5:0][EW-1:0] edge_d;
  logic               v1;
  logic [5:0]         eneg;
  logic [5:0][CW-1:0] emag;

  always_comb begin
    edge_d[0] = {second_x[CW-1], second_x} - {first_x[CW-1], first_x};
    edge_d[1] = {second_y[CW-1], second_y} - {first_y[CW-1], first_y};
    edge_d[2] = {second_z[CW-1], second_z} - {first_z[CW-1], first_z};
    edge_d[3] = {third_x[CW-1], third_x} - {first_x[CW-1], first_x};
    edge_d[4] = {third_y[CW-1], third_y} - {first_y[CW-1], first_y};
    edge_d[5] = {third_z[CW-1], third_z} - {first_z[CW-1], first_z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      logic [EW-1:0] a;
      a       = edge_d[i][EW-1] ? (~edge_d[i] + EW'(1)) : edge_d[i];
      eneg[i] <= edge_d[i][EW-1];
      emag[i] <= a[CW-1:0];
    end
  end

  // ---------------- products ----------------
  // pairs: (uy,vz) (uz,vy) | (uz,vx) (ux,vz) | (ux,vy) (uy,vx)
  localparam int PA [6] = '{1, 2, 2, 0, 0, 1};
  localparam int PB [6] = '{5, 4, 3, 5, 4, 3};

  logic               v2;
  logic [5:0][PW-1:0] prod;
  logic [5:0]         pneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      prod[i] <= PW'(emag[PA[i]]) * PW'(emag[PB[i]]);
      pneg[i] <= eneg[PA[i]] ^ eneg[PB[i]];
    end
  end

  // ---------------- cross terms ----------------
  logic               v3;
  logic [2:0][NW-1:0] cmag;
  logic [2:0]         cneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic sp, sq;
      logic [PW-1:0] mp, mq;
      mp = prod[2*i];
      mq = prod[2*i+1];
      sp = pneg[2*i];
      sq = !pneg[2*i+1];
      if (sp == sq) begin
        cmag[i] <= NW'(mp) + NW'(mq);
        cneg[i] <= sp;
      end else if (mp >= mq) begin
        cmag[i] <= NW'(mp - mq);
        cneg[i] <= sp;
      end else begin
        cmag[i] <= NW'(mq - mp);
        cneg[i] <= sq;
      end
    end
  end

  // ---------------- largest magnitude ----------------
  logic [NW-1:0] big01, big_c;

  always_comb begin
    big01 = (cmag[1] > cmag[0]) ? cmag[1] : cmag[0];
    big_c = (cmag[2] > big01) ? cmag[2] : big01;
  end

  logic [NSH:0]              sh_valid;
  logic [NSH:0]              sh_degen;
  logic [NSH:0][2:0]         sh_neg;
  logic [NSH:0][2:0][MW-1:0] sh_mag;
  logic [NSH:0][MW-1:0]      sh_big;

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_valid[0] <= 1'b0;
    end else begin
      sh_valid[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    sh_degen[0] <= big_c == '0;
    sh_neg[0]   <= cneg;
    for (int i = 0; i < 3; i++) begin
      sh_mag[0][i] <= MW'(cmag[i]);
    end
    sh_big[0] <= MW'(big_c);
  end

  // ---------------- prescale chain ----------------
  // binary steps 32..1 find the last shift that leaves 2^31 or more,
  // the final step shifts once more if the largest is still 2^31 or more
  for (genvar g = 0; g < NSH; g++) begin : g_shift
    localparam int TS = (g == NSH - 1) ? 0 : (32 >> g);
    localparam int SA = (g == NSH - 1) ? 1 : (32 >> g);
    tun_shift_cell #(
      .MW(MW), .TEST_SHIFT(TS), .SHIFT(SA)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sh_valid[g]),
      .in_degen (sh_degen[g]),
      .in_neg   (sh_neg[g]),
      .in_mag   (sh_mag[g]),
      .in_big   (sh_big[g]),
      .out_valid(sh_valid[g+1]),
      .out_degen(sh_degen[g+1]),
      .out_neg  (sh_neg[g+1]),
      .out_mag  (sh_mag[g+1]),
      .out_big  (sh_big[g+1])
    );
  end

  // ---------------- squares ----------------
  logic                      vq;
  logic                      qdegen;
  logic [2:0]                qneg;
  logic [2:0][MAG_WIDTH-1:0] qm;
  logic [2:0][SQ_WIDTH-1:0]  qsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else begin
      vq <= sh_valid[NSH];
    end
  end

  always_ff @(posedge clk) begin
    qdegen <= sh_degen[NSH];
    qneg   <= sh_neg[NSH];
    for (int i = 0; i < 3; i++) begin
      qm[i]  <= sh_mag[NSH][i][MAG_WIDTH-1:0];
      qsq[i] <= SQ_WIDTH'(sh_mag[NSH][i][MAG_WIDTH-1:0])
              * SQ_WIDTH'(sh_mag[NSH][i][MAG_WIDTH-1:0]);
    end
  end

  // ---------------- sum of squares, head of root chain ----------------
  sq_t sq_chain [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_chain[0].valid <= 1'b0;
    end else begin
      sq_chain[0].valid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    sq_chain[0].degen <= qdegen;
    sq_chain[0].neg   <= qneg;
    sq_chain[0].m     <= qm;
    sq_chain[0].n     <= SUM_WIDTH'(qsq[0]) + SUM_WIDTH'(qsq[1]) + SUM_WIDTH'(qsq[2]);
    sq_chain[0].res   <= '0;
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    tun_sqrt_cell #(.BIT_IDX(SQRT_STEPS - 1 - g)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .in_rec (sq_chain[g]),
      .out_rec(sq_chain[g+1])
    );
  end

  // ---------------- divider chain ----------------
  div_t div_chain [QUO_BITS+1];

  always_comb begin
    div_chain[0].valid = sq_chain[SQRT_STEPS].valid;
    div_chain[0].degen = sq_chain[SQRT_STEPS].degen;
    div_chain[0].neg   = sq_chain[SQRT_STEPS].neg;
    div_chain[0].len   = sq_chain[SQRT_STEPS].res[LEN_WIDTH-1:0];
    div_chain[0].q     = '0;
    for (int i = 0; i < 3; i++) begin
      // rounded numerator m * 2^14 + len / 2
      div_chain[0].rem[i] = (REM_WIDTH'(sq_chain[SQRT_STEPS].m[i]) << FRAC_BITS)
                          + REM_WIDTH'(sq_chain[SQRT_STEPS].res[LEN_WIDTH-1:1]);
    end
  end

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
    tun_div_cell #(.BIT_IDX(QUO_BITS - 1 - g)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .in_rec (div_chain[g]),
      .out_rec(div_chain[g+1])
    );
  end

  // ---------------- output register ----------------
  logic [2:0][OUT_WIDTH-1:0] res_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [OUT_WIDTH-1:0] u;
      u = OUT_WIDTH'(div_chain[QUO_BITS].q[i]);
      if (div_chain[QUO_BITS].degen) begin
        res_c[i] = '0;
      end else if (div_chain[QUO_BITS].neg[i]) begin
        res_c[i] = ~u + OUT_WIDTH'(1);
      end else begin
        res_c[i] = u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_chain[QUO_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    normal_x   <= res_c[0];
    normal_y   <= res_c[1];
    normal_z   <= res_c[2];
    degenerate <= div_chain[QUO_BITS].degen;
  end

endmodule

@@ rtl/tun_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_checker
// Port level checks of the triangle unit normal block, bound to the top.
// ----------------------------------------------------------------------------
module tun_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  done,
  input logic signed [tun_pkg::OUT_WIDTH-1:0]  normal_x,
  input logic signed [tun_pkg::OUT_WIDTH-1:0]  normal_y,
  input logic signed [tun_pkg::OUT_WIDTH-1:0]  normal_z,
  input logic                                  degenerate
);
  import tun_pkg::*;

  // the pipeline never stalls a transfer
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("transfer refused while start is high");

  // a degenerate triangle gives a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate result with nonzero normal");

  // a proper normal is never the zero vector
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
    else $error("zero normal without degenerate flag");

  // components stay within one unit
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> normal_x >= UNIT_NEG && normal_x <= UNIT_POS
          && normal_y >= UNIT_NEG && normal_y <= UNIT_POS
          && normal_z >= UNIT_NEG && normal_z <= UNIT_POS)
    else $error("normal component out of range");

  // no result in the cycle after reset
  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (.*);
